>>> hdl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// shared types and constants of the laplacian sharpness measure
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 50;
    localparam int MEAN_W     = 28;
    localparam int FRAC_W     = 8;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int LAP_MAG_W  = 10;
    localparam int SQ_W       = 20;
    localparam int DIV_STEPS  = SUM_W + FRAC_W;
    localparam int DIV_CNT_W  = 6;
    localparam int PADDR_W    = 3;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LEFT,
        S_RD_CENTER,
        S_RD_RIGHT,
        S_CALC,
        S_ACC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> hdl/laplacian_sharpness_measure.sv
// per pixel: three line store reads, square, accumulate; a new pixel is
//   taken only once the previous one is through; the last pixel of a frame
//   adds a final-row flush, a bit-serial mean division and a load of the
//   result register
// reset: synchronous active-low; counters, sum and handshake cleared,
//   line stores keep contents and need no clearing pass
// ----------------------------------------------------------------------------
// laplacian_sharpness_measure
// streamed 4-neighbour laplacian energy with exact sum and fixed-point mean
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_sharpness_measure #(
    parameter int MAX_WIDTH = 4096,
    parameter int CHANNELS  = 3
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [lsm_pkg::PIX_W-1:0]          i_red,
    input  wire  [lsm_pkg::PIX_W-1:0]          i_green,
    input  wire  [lsm_pkg::PIX_W-1:0]          i_blue,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [lsm_pkg::SUM_W-1:0]          o_square_sum,
    output logic [lsm_pkg::MEAN_W-1:0]         o_mean_fixed,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [lsm_pkg::PADDR_W-1:0]        paddr,
    input  wire  [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import lsm_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int DW    = PIX_W * CHANNELS;
    localparam int WH_W  = EW + HEIGHT_W;
    localparam int CNT_W = WH_W + $clog2(CHANNELS + 1);
    localparam int QW    = DIV_STEPS;

    t_state r_state, n_state;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [EW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [WH_W-1:0]     r_wh;
    logic [CNT_W-1:0]    r_count;

    logic [DW-1:0]       r_line0 [MAX_WIDTH];
    logic [DW-1:0]       r_line1 [MAX_WIDTH];
    logic [DW-1:0]       r_rd0, r_rd1;
    logic [AW-1:0]       rd_addr;
    logic [DW-1:0]       mid_rd, up_rd;
    logic                r_sel;

    logic [DW-1:0]       pix_in;
    logic [DW-1:0]       r_pix;
    logic [DW-1:0]       r_left, r_center, r_up;
    logic [AW-1:0]       r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic                r_flush;
    logic                last_col, has_up, do_add;

    logic [SQ_W-1:0]     r_sq [CHANNELS];
    logic [SUM_W-1:0]    r_acc, n_acc;

    logic [CNT_W-1:0]    r_rem;
    logic [QW-1:0]       r_quo;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [CNT_W:0]      div_sh;

    logic                cfg_wr, out_free, in_acc;
    logic                r_out_valid_q;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_WIDTH) ? 32'(r_width) : 32'(r_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[WIDTH_W-1:0];
            end else begin
                r_height <= pwdata[HEIGHT_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = EW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_width);
        end
        h_eff = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    end

    always_ff @(posedge i_clk) begin
        r_wh    <= WH_W'(w_eff) * WH_W'(h_eff);
        r_count <= CNT_W'(r_wh) * CNT_W'(CHANNELS);
    end

    // input pixel packing, channel k at bits [8k +: 8]
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            if (k == 0) begin
                pix_in[k*PIX_W +: PIX_W] = i_red;
            end else if (k == 1) begin
                pix_in[k*PIX_W +: PIX_W] = i_green;
            end else if (k == 2) begin
                pix_in[k*PIX_W +: PIX_W] = i_blue;
            end else begin
                pix_in[k*PIX_W +: PIX_W] = '0;
            end
        end
    end

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid_q || !i_stall;
    assign last_col = !((EW'(r_col) + EW'(1)) < w_eff);
    assign has_up   = r_flush ? (r_row >= HEIGHT_W'(1)) : (r_row >= HEIGHT_W'(2));
    assign do_add   = r_flush || (r_row >= HEIGHT_W'(1));

    // line stores; upper line is r_line[sel], middle line the other
    always_comb begin
        unique case (r_state)
            S_RD_LEFT:   rd_addr = r_col - AW'(1);
            S_RD_RIGHT:  rd_addr = r_col + AW'(1);
            default:     rd_addr = r_col;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_line0[rd_addr];
        r_rd1 <= r_line1[rd_addr];
        if (r_state == S_ACC && !r_flush) begin
            if (r_sel) begin
                r_line1[r_col] <= r_pix;
            end else begin
                r_line0[r_col] <= r_pix;
            end
        end
    end

    assign mid_rd = r_sel ? r_rd0 : r_rd1;
    assign up_rd  = r_sel ? r_rd1 : r_rd0;

    // fsm next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_valid) n_state = S_RD_LEFT;
            S_RD_LEFT:   n_state = S_RD_CENTER;
            S_RD_CENTER: n_state = S_RD_RIGHT;
            S_RD_RIGHT:  n_state = S_CALC;
            S_CALC:      n_state = S_ACC;
            S_ACC: begin
                if (r_flush) begin
                    n_state = last_col ? S_DIV : S_RD_LEFT;
                end else if (last_col && !((r_row + HEIGHT_W'(1)) < h_eff)) begin
                    n_state = S_RD_LEFT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV:       if (r_dcnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_OUT;
            S_OUT:       if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_stall = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // laplacian and squares
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix <= pix_in;
        end
        if (r_state == S_RD_CENTER) begin
            r_left <= mid_rd;
        end
        if (r_state == S_RD_RIGHT) begin
            r_center <= mid_rd;
            r_up     <= up_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            for (int k = 0; k < CHANNELS; k++) begin
                logic signed [11:0]      lap;
                logic [LAP_MAG_W-1:0]    mag;
                lap = 12'sd0;
                if (has_up) lap = lap + $signed({4'b0, r_up[k*PIX_W +: PIX_W]});
                if (!r_flush) lap = lap + $signed({4'b0, r_pix[k*PIX_W +: PIX_W]});
                if (r_col != '0) lap = lap + $signed({4'b0, r_left[k*PIX_W +: PIX_W]});
                if (!last_col) lap = lap + $signed({4'b0, mid_rd[k*PIX_W +: PIX_W]});
                lap = lap - $signed({2'b0, r_center[k*PIX_W +: PIX_W], 2'b0});
                mag = lap[11] ? LAP_MAG_W'(-lap) : LAP_MAG_W'(lap);
                r_sq[k] <= SQ_W'(mag) * SQ_W'(mag);
            end
        end
    end

    always_comb begin
        n_acc = r_acc;
        for (int k = 0; k < CHANNELS; k++) begin
            n_acc = n_acc + SUM_W'(r_sq[k]);
        end
    end

    // divider step
    assign div_sh = {r_rem, r_quo[QW-1]};

    // counters, accumulator, divider, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_acc         <= '0;
            r_flush       <= 1'b0;
            r_sel         <= 1'b0;
            r_dcnt        <= '0;
            r_out_valid_q <= 1'b0;
        end else begin
            if (r_out_valid_q && !i_stall && r_state != S_OUT) begin
                r_out_valid_q <= 1'b0;
            end
            if (cfg_wr) begin
                r_acc   <= '0;
                r_row   <= '0;
                r_col   <= '0;
                r_flush <= 1'b0;
            end else begin
                unique case (r_state)
                    S_ACC: begin
                        if (do_add) begin
                            r_acc <= n_acc;
                        end
                        if (!last_col) begin
                            r_col <= r_col + AW'(1);
                        end else begin
                            r_col <= '0;
                            if (r_flush) begin
                                r_flush <= 1'b0;
                                r_dcnt  <= '0;
                                r_rem   <= '0;
                                r_quo   <= {n_acc, FRAC_W'(0)};
                            end else begin
                                r_sel <= !r_sel;
                                if ((r_row + HEIGHT_W'(1)) < h_eff) begin
                                    r_row <= r_row + HEIGHT_W'(1);
                                end else begin
                                    r_flush <= 1'b1;
                                end
                            end
                        end
                    end
                    S_DIV: begin
                        r_dcnt <= r_dcnt + DIV_CNT_W'(1);
                        if (div_sh >= {1'b0, r_count}) begin
                            r_rem <= CNT_W'(div_sh - {1'b0, r_count});
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= CNT_W'(div_sh);
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                    end
                    S_OUT: begin
                        if (out_free) begin
                            r_out_valid_q <= 1'b1;
                            o_square_sum  <= r_acc;
                            o_mean_fixed  <= r_quo[MEAN_W-1:0];
                            r_acc         <= '0;
                            r_row         <= '0;
                            r_col         <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid = r_out_valid_q;

    // assertions
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (EW'(r_col) < w_eff))
        else $error("column counter beyond frame width");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt < DIV_CNT_W'(DIV_STEPS)))
        else $error("divider step count overrun");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_valid && r_acc == '0))
        else $error("result not loaded at end of frame");

    a_no_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_flush)
        else $error("input taken during final row flush");

endmodule

`default_nettype wire

>>> tb/sv/laplacian_sharpness_measure_test.sv
// ----------------------------------------------------------------------------
// laplacian_sharpness_measure_test
// self-checking bench: whole frames are streamed in, the frame energy and
// fixed-point mean are predicted in the bench and compared per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_sharpness_measure_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsm_pkg::*;

    localparam int LINE_DEPTH = 4096;
    localparam int NUM_CH     = 3;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [SUM_W-1:0]  square_sum;
        logic [MEAN_W-1:0] mean_fixed;
    } t_focus;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [PIX_W-1:0]    i_red;
    logic [PIX_W-1:0]    i_green;
    logic [PIX_W-1:0]    i_blue;
    logic                o_valid;
    logic                i_stall;
    logic [SUM_W-1:0]    o_square_sum;
    logic [MEAN_W-1:0]   o_mean_fixed;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    laplacian_sharpness_measure dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_square_sum (o_square_sum),
        .o_mean_fixed (o_mean_fixed),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // predictor state
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [7:0]          upper_row [LINE_DEPTH][NUM_CH];
    logic [7:0]          middle_row [LINE_DEPTH][NUM_CH];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [63:0]         energy;

    t_focus expected_focus [$];
    int     error_count;
    int     items_sent;
    int     idle_cycles;
    int     hold_cycles;
    bit     quiet;
    bit     send_idling;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
        return int'(cfg_width);
    endfunction

    function automatic void add_energy(int unsigned c, int unsigned w, bit has_up,
                                       int down [NUM_CH]);
        int lap;
        for (int k = 0; k < NUM_CH; k++) begin
            lap = down[k] - 4 * int'(middle_row[c][k]);
            if (has_up) lap += int'(upper_row[c][k]);
            if (c > 0) lap += int'(middle_row[c-1][k]);
            if (c + 1 < w) lap += int'(middle_row[c+1][k]);
            energy = (energy + 64'(lap * lap)) & ((64'd1 << SUM_W) - 1);
        end
    endfunction

    function automatic bit frame_energy_step(input logic [7:0] r, g, b,
                                             output t_focus res);
        int unsigned w = eff_width();
        int unsigned h = (cfg_height == 0) ? 1 : int'(cfg_height);
        int unsigned c = col_pos;
        int pix [NUM_CH];
        int zero [NUM_CH];
        logic [7:0] t;
        logic [63:0] count;
        if (c >= w) c = w - 1;
        pix[0] = int'(r); pix[1] = int'(g); pix[2] = int'(b);
        for (int k = 0; k < NUM_CH; k++) zero[k] = 0;
        if (row_pos >= 1) add_energy(c, w, row_pos >= 2, pix);
        for (int k = 0; k < NUM_CH; k++) upper_row[c][k] = 8'(pix[k]);
        if (c + 1 < w) begin
            col_pos = c + 1;
            return 1'b0;
        end
        for (int j = 0; j < w; j++) begin
            for (int k = 0; k < NUM_CH; k++) begin
                t = upper_row[j][k];
                upper_row[j][k] = middle_row[j][k];
                middle_row[j][k] = t;
            end
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos = row_pos + 1;
            return 1'b0;
        end
        for (int j = 0; j < w; j++) add_energy(j, w, row_pos >= 1, zero);
        count = 64'(w) * 64'(h) * 64'(NUM_CH);
        res.square_sum = energy[SUM_W-1:0];
        res.mean_fixed = MEAN_W'((energy << FRAC_W) / count);
        row_pos = 0;
        energy = 0;
        return 1'b1;
    endfunction

    task automatic reg_write(input logic sel_height, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= (sel_height == REG_HEIGHT) ? PADDR_W'(4) : PADDR_W'(0);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel_height == REG_HEIGHT) cfg_height = value[HEIGHT_W-1:0];
        else cfg_width = value[WIDTH_W-1:0];
        col_pos = 0;
        row_pos = 0;
        energy = 0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_focus.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
        wait_drained();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    task automatic send_pixel(input logic [7:0] r, g, b);
        t_focus res;
        i_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (o_stall);
        if (frame_energy_step(r, g, b, res)) expected_focus.push_back(res);
        items_sent++;
        if (send_idling && !quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h, input int mode);
        for (int i = 0; i < w * h; i++) begin
            case (mode)
                0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                1: send_pixel((i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff,
                              ((i / w) % 2) ? 8'hff : 8'h00);
                default: send_pixel(8'hff, 8'hff, 8'hff);
            endcase
        end
    endtask

    task automatic test_directed();
        set_frame(3, 3);
        send_frame(3, 3, 1);
        set_frame(1, 1);
        send_pixel(8'hff, 8'h00, 8'hff);
        set_frame(0, 0);
        send_pixel(8'h00, 8'hff, 8'h00);
        set_frame(2, 3);
        send_frame(2, 3, 2);
        set_frame(3, 1);
        send_frame(3, 1, 1);
    endtask

    task automatic test_extreme_registers();
        set_frame(2, 65535);
        set_frame(8191, 1);
        set_frame(7, 0);
        send_frame(7, 1, 0);
    endtask

    task automatic test_random_frames(input int target);
        int unsigned w, h;
        while (items_sent < target) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_frame(w, h);
            repeat ($urandom_range(1, 4)) begin
                send_idling = $urandom_range(0, 2) != 0;
                send_frame(w, h, ($urandom_range(0, 9) == 0) ? 1 : 0);
                if ($urandom_range(0, 3) == 0) wait_drained();
            end
        end
    endtask

    task automatic test_backpressure();
        set_frame(2, 2);
        send_idling = 1'b0;
        hold_cycles = 400;
        repeat (4) send_frame(2, 2, 0);
        wait_drained();
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        set_frame(5, 4);
        repeat (8) send_frame(5, 4, 0);
    endtask

    always @(posedge i_clk) begin
        t_focus want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_focus.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(o_square_sum), 64'd0);
            end else begin
                want = expected_focus.pop_front();
                if (o_square_sum !== want.square_sum)
                    report_mismatch("square_sum", 64'(o_square_sum), 64'(want.square_sum));
                if (o_mean_fixed !== want.mean_fixed)
                    report_mismatch("mean_fixed", 64'(o_mean_fixed), 64'(want.mean_fixed));
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[laplacian_sharpness_measure] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        items_sent = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        send_idling = 1'b1;
        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        energy = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_extreme_registers();
        test_backpressure();
        test_random_frames(1700);
        test_full_rate();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[laplacian_sharpness_measure] OK");
        end else begin
            $display("[laplacian_sharpness_measure] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> laplacian_sharpness_measure.f
hdl/lsm_pkg.sv
hdl/laplacian_sharpness_measure.sv
tb/sv/laplacian_sharpness_measure_test.sv
